// File: rtl/anp_pkg.sv
package anp_pkg;

	// Text and fraction limits
	localparam int unsigned MAX_TEXT_LENGTH     = 65535;
	localparam int unsigned MAX_FRACTION_DIGITS = 7;
	localparam int unsigned POS_W               = $clog2(MAX_TEXT_LENGTH + 1);
	localparam int unsigned FRAC_W              = 24;
	localparam int unsigned FLEN_W              = 3;
	localparam int unsigned ACC_W               = 64;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SYNTAX   = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_FRACLONG = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	// Base selection codes
	localparam logic [2:0] BASE_AUTO = 3'd0;
	localparam logic [2:0] BASE_BIN  = 3'd1;
	localparam logic [2:0] BASE_OCT  = 3'd2;
	localparam logic [2:0] BASE_DEC  = 3'd3;
	localparam logic [2:0] BASE_HEX  = 3'd4;

	// Target integer kinds
	localparam logic [3:0] KIND_U64  = 4'd0;
	localparam logic [3:0] KIND_U32  = 4'd1;
	localparam logic [3:0] KIND_U16  = 4'd2;
	localparam logic [3:0] KIND_U8   = 4'd3;
	localparam logic [3:0] KIND_S8   = 4'd4;
	localparam logic [3:0] KIND_S16  = 4'd5;
	localparam logic [3:0] KIND_S32  = 4'd6;
	localparam logic [3:0] KIND_S64  = 4'd7;
	localparam logic [3:0] KIND_REAL = 4'd8;

	// Configuration register indexes
	localparam logic [1:0] CFG_BASE_MODE      = 2'd0;
	localparam logic [1:0] CFG_TRIM_BLANKS    = 2'd1;
	localparam logic [1:0] CFG_ALLOW_TRAILING = 2'd2;
	localparam logic [1:0] CFG_TARGET_KIND    = 2'd3;

	typedef struct packed {
		logic [2:0] base_mode;
		logic       trim_blanks;
		logic       allow_trailing;
		logic [3:0] target_kind;
	} anp_cfg_t;

	// Final parse state of one string, handed to the result stage
	typedef struct packed {
		logic [2:0]        err;
		logic [ACC_W-1:0]  acc;
		logic              minus;
		logic              point;
		logic [FRAC_W-1:0] frac;
		logic [FLEN_W-1:0] flen;
		logic [POS_W-1:0]  consumed;
	} anp_snap_t;

endpackage

// File: rtl/anp_scan.sv
module anp_scan import anp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       char_code,
	input  logic             last_char,
	input  anp_cfg_t         cfg,
	output logic             snap_valid,
	input  logic             snap_ready,
	output anp_snap_t        snap
);

	typedef enum logic [2:0] {
		PH_LEAD, PH_POSTSIGN, PH_PREFIX, PH_POSTPREFIX, PH_INT, PH_FRAC, PH_TAIL, PH_DONE
	} phase_t;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [4:0] RADIX_2  = 5'd2;
	localparam logic [4:0] RADIX_8  = 5'd8;
	localparam logic [4:0] RADIX_10 = 5'd10;
	localparam logic [4:0] RADIX_16 = 5'd16;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_LENGTH);

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Parse state
	phase_t            phase_q;
	logic [4:0]        radix_q;
	logic [ACC_W-1:0]  acc_q;
	logic              minus_q;
	logic              point_q;
	logic [FRAC_W-1:0] frac_q;
	logic [FLEN_W-1:0] flen_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  stop_q;
	logic [2:0]        err_q;

	phase_t            phase_n;
	logic [4:0]        radix_n;
	logic [ACC_W-1:0]  acc_n;
	logic              minus_n;
	logic              point_n;
	logic [FRAC_W-1:0] frac_n;
	logic [FLEN_W-1:0] flen_n;
	logic [POS_W-1:0]  pos_n;
	logic [POS_W-1:0]  stop_n;
	logic [2:0]        err_n;
	logic [POS_W-1:0]  consumed;

	logic fire_s1;

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			return {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			return {1'b1, 4'(c - 8'h57)};
		end
		return 5'd0;
	endfunction

	// acc * radix + digit, four guard bits catch the overflow
	function automatic logic [ACC_W+3:0] mul_add(input logic [ACC_W-1:0] a,
			input logic [4:0] r, input logic [3:0] d);
		logic [ACC_W+3:0] w;
		logic [ACC_W+3:0] p;
		w = {4'b0, a};
		case (r)
			RADIX_2:  p = w << 1;
			RADIX_8:  p = w << 3;
			RADIX_16: p = w << 4;
			default:  p = (w << 3) + (w << 1);
		endcase
		return p + {{(ACC_W){1'b0}}, d};
	endfunction

	assign fire_s1    = valid_s1 && (!last_s1 || snap_ready);
	assign in_ready   = !valid_s1 || fire_s1;
	assign snap_valid = valid_s1 && last_s1;

	always_comb begin
		logic             go;
		logic             skip;
		logic [4:0]       dig;
		logic [ACC_W+3:0] prod;
		logic [7:0]       low;
		phase_n = phase_q;
		radix_n = radix_q;
		acc_n   = acc_q;
		minus_n = minus_q;
		point_n = point_q;
		frac_n  = frac_q;
		flen_n  = flen_q;
		stop_n  = stop_q;
		err_n   = err_q;
		go      = 1'b1;
		skip    = cfg.trim_blanks && (char_s1 == CH_SPACE || char_s1 == CH_TAB);
		dig     = digit_of(char_s1);
		low     = char_s1 | CASE_BIT;
		prod    = '0;

		// Phases only move forward, so one ordered pass resolves the chain
		if (phase_n == PH_LEAD) begin
			if (skip) begin
				go = 1'b0;
			end else begin
				phase_n = PH_POSTSIGN;
				if (char_s1 == CH_PLUS) begin
					go = 1'b0;
				end else if (char_s1 == CH_MINUS) begin
					minus_n = 1'b1;
					go = 1'b0;
				end
			end
		end
		if (go && phase_n == PH_POSTSIGN) begin
			if (skip) begin
				go = 1'b0;
			end else begin
				phase_n = PH_INT;
				case (cfg.base_mode)
					BASE_AUTO: begin
						radix_n = RADIX_10;
						if (char_s1 == CH_ZERO) begin
							phase_n = PH_PREFIX;
							go = 1'b0;
						end
					end
					BASE_BIN: radix_n = RADIX_2;
					BASE_OCT: radix_n = RADIX_8;
					BASE_DEC: radix_n = RADIX_10;
					BASE_HEX: radix_n = RADIX_16;
					default: begin
						err_n = ST_SYNTAX;
						phase_n = PH_DONE;
						go = 1'b0;
					end
				endcase
			end
		end
		if (go && phase_n == PH_PREFIX) begin
			if (low == CH_LOW_B) begin
				radix_n = RADIX_2;
				phase_n = PH_POSTPREFIX;
				go = 1'b0;
			end else if (low == CH_LOW_X) begin
				radix_n = RADIX_16;
				phase_n = PH_POSTPREFIX;
				go = 1'b0;
			end else begin
				radix_n = RADIX_8;
				phase_n = PH_INT;
			end
		end
		if (go && phase_n == PH_POSTPREFIX) begin
			if (skip) begin
				go = 1'b0;
			end else begin
				phase_n = PH_INT;
			end
		end
		if (go && phase_n == PH_INT) begin
			prod = mul_add(acc_q, radix_n, dig[3:0]);
			if (dig[4] && {1'b0, dig[3:0]} < radix_n) begin
				if (prod[ACC_W+3:ACC_W] != 4'd0) begin
					err_n = ST_OVERFLOW;
					phase_n = PH_DONE;
				end else begin
					acc_n = prod[ACC_W-1:0];
				end
				go = 1'b0;
			end else if (char_s1 == CH_POINT) begin
				point_n = 1'b1;
				phase_n = PH_FRAC;
				go = 1'b0;
			end else begin
				phase_n = PH_TAIL;
			end
		end
		if (go && phase_n == PH_FRAC) begin
			if (dig[4] && dig[3:0] <= 4'd9) begin
				if (flen_q >= FLEN_W'(MAX_FRACTION_DIGITS)) begin
					err_n = ST_FRACLONG;
					phase_n = PH_DONE;
				end else begin
					frac_n = (frac_q << 3) + (frac_q << 1) + {{(FRAC_W-4){1'b0}}, dig[3:0]};
					flen_n = flen_q + 1'b1;
				end
				go = 1'b0;
			end else begin
				phase_n = PH_TAIL;
			end
		end
		if (go && phase_n == PH_TAIL) begin
			if (!skip) begin
				if (cfg.allow_trailing) begin
					stop_n = pos_q;
					phase_n = PH_DONE;
				end else begin
					err_n = ST_SYNTAX;
					phase_n = PH_DONE;
				end
			end
		end

		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

		// A string that ends before any digit position is malformed
		if (last_s1 && err_n == ST_OK && (phase_n == PH_LEAD || phase_n == PH_POSTSIGN ||
				phase_n == PH_POSTPREFIX)) begin
			err_n = ST_SYNTAX;
			phase_n = PH_DONE;
		end

		if (!cfg.allow_trailing) begin
			consumed = '0;
		end else if (phase_n == PH_DONE && err_n == ST_OK) begin
			consumed = stop_n;
		end else begin
			consumed = pos_n;
		end
	end

	always_comb begin
		snap.err      = err_n;
		snap.acc      = acc_n;
		snap.minus    = minus_n;
		snap.point    = point_n;
		snap.frac     = frac_n;
		snap.flen     = flen_n;
		snap.consumed = consumed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			radix_q <= RADIX_10;
			acc_q   <= '0;
			minus_q <= 1'b0;
			point_q <= 1'b0;
			frac_q  <= '0;
			flen_q  <= '0;
			pos_q   <= '0;
			stop_q  <= '0;
			err_q   <= ST_OK;
		end else if (fire_s1) begin
			if (last_s1) begin
				phase_q <= PH_LEAD;
				radix_q <= RADIX_10;
				acc_q   <= '0;
				minus_q <= 1'b0;
				point_q <= 1'b0;
				frac_q  <= '0;
				flen_q  <= '0;
				pos_q   <= '0;
				stop_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				radix_q <= radix_n;
				acc_q   <= acc_n;
				minus_q <= minus_n;
				point_q <= point_n;
				frac_q  <= frac_n;
				flen_q  <= flen_n;
				pos_q   <= pos_n;
				stop_q  <= stop_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

// File: rtl/anp_result.sv
module anp_result import anp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        target_kind,
	input  logic              snap_valid,
	output logic              snap_ready,
	input  anp_snap_t         snap,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [ACC_W-1:0]  int_value,
	output logic              is_negative,
	output logic              has_fraction,
	output logic [FRAC_W-1:0] fraction_digits,
	output logic [FLEN_W-1:0] fraction_count,
	output logic [POS_W-1:0]  consumed_length
);

	localparam logic [ACC_W-1:0] LIM_S8  = ACC_W'(64'h80);
	localparam logic [ACC_W-1:0] LIM_S16 = ACC_W'(64'h8000);
	localparam logic [ACC_W-1:0] LIM_S32 = ACC_W'(64'h8000_0000);
	localparam logic [ACC_W-1:0] LIM_S64 = ACC_W'(64'h8000_0000_0000_0000);

	logic      valid_s2;
	anp_snap_t snap_s2;
	logic      out_free;

	logic [2:0]       st;
	logic [ACC_W-1:0] val;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [ACC_W-1:0] value_q;
	logic             neg_q;
	logic             point_q;
	logic [FRAC_W-1:0] frac_q;
	logic [FLEN_W-1:0] flen_q;
	logic [POS_W-1:0] consumed_q;

	assign out_free   = !out_valid_q || out_ready;
	assign snap_ready = !valid_s2 || out_free;

	always_comb begin
		logic [ACC_W-1:0] m;
		logic [ACC_W-1:0] lim;
		m   = snap_s2.acc;
		st  = snap_s2.err;
		val = m;
		case (target_kind)
			KIND_S8:  lim = LIM_S8;
			KIND_S16: lim = LIM_S16;
			KIND_S32: lim = LIM_S32;
			default:  lim = LIM_S64;
		endcase
		if (st == ST_OK && target_kind < KIND_REAL) begin
			if (snap_s2.point) begin
				st = ST_SYNTAX;
			end else if (target_kind <= KIND_U8) begin
				if (snap_s2.minus) begin
					st = ST_RANGE;
				end else begin
					case (target_kind)
						KIND_U32: if (m[63:32] != '0) st = ST_RANGE;
						KIND_U16: if (m[63:16] != '0) st = ST_RANGE;
						KIND_U8:  if (m[63:8] != '0) st = ST_RANGE;
						default:  st = ST_OK;
					endcase
				end
			end else if (snap_s2.minus) begin
				if (m > lim) begin
					st = ST_RANGE;
				end else begin
					val = '0 - m;
				end
			end else if (m >= lim) begin
				st = ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (snap_ready) begin
				valid_s2 <= snap_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			snap_s2 <= snap;
		end
		if (out_free && valid_s2) begin
			status_q   <= st;
			value_q    <= (st == ST_OK) ? val : '0;
			neg_q      <= snap_s2.minus;
			point_q    <= snap_s2.point;
			frac_q     <= (st == ST_OK) ? snap_s2.frac : '0;
			flen_q     <= (st == ST_OK) ? snap_s2.flen : '0;
			consumed_q <= snap_s2.consumed;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign int_value       = value_q;
	assign is_negative     = neg_q;
	assign has_fraction    = point_q;
	assign fraction_digits = frac_q;
	assign fraction_count  = flen_q;
	assign consumed_length = consumed_q;

endmodule

// File: rtl/ascii_number_parser_core.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    char_code[7:0], last_char
// config    cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[3:0]
// output    out_valid / out_ready  status, int_value, is_negative, has_fraction,
//                                  fraction_digits, fraction_count, consumed_length
//
// One character is taken every cycle unless a finished string is held back by the result
// stage; the parse state loop (digit check plus one shift-add multiply by the radix) is
// combinational after the input register. The result of a string passes through a
// snapshot register and the range-check output register.
// Reset restores the power-up configuration and an empty parse; no clearing pass.
// A stalled output backs up the snapshot, then the input register, then in_ready.
module ascii_number_parser_core import anp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [ACC_W-1:0]  int_value,
	output logic              is_negative,
	output logic              has_fraction,
	output logic [FRAC_W-1:0] fraction_digits,
	output logic [FLEN_W-1:0] fraction_count,
	output logic [POS_W-1:0]  consumed_length
);

	anp_cfg_t  cfg_q;
	anp_snap_t snap;
	logic      snap_valid;
	logic      snap_ready;

	// Always writable; the host must write registers only while no item is in flight
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_mode      <= BASE_DEC;
			cfg_q.trim_blanks    <= 1'b1;
			cfg_q.allow_trailing <= 1'b0;
			cfg_q.target_kind    <= KIND_U64;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE_MODE:      cfg_q.base_mode      <= cfg_data[2:0];
				CFG_TRIM_BLANKS:    cfg_q.trim_blanks    <= cfg_data[0];
				CFG_ALLOW_TRAILING: cfg_q.allow_trailing <= cfg_data[0];
				CFG_TARGET_KIND:    cfg_q.target_kind    <= cfg_data;
				default:            cfg_q.target_kind    <= cfg_q.target_kind;
			endcase
		end
	end

	// Scanner: input register and the per-character parse state machine
	anp_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.cfg        (cfg_q),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	// Result: hold the finished parse, range-check it and present the item
	anp_result u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.target_kind     (cfg_q.target_kind),
		.snap_valid      (snap_valid),
		.snap_ready      (snap_ready),
		.snap            (snap),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.int_value       (int_value),
		.is_negative     (is_negative),
		.has_fraction    (has_fraction),
		.fraction_digits (fraction_digits),
		.fraction_count  (fraction_count),
		.consumed_length (consumed_length)
	);

endmodule
